// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the page table walker RTL.
// Defining ASSERT_OFF turns every check into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define PTW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The condition must never be true outside reset.
`define PTW_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PTW_ASSERT(name, clk, rst, prop, msg)
`define PTW_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/ptw_pkg.sv -----
// Shared types and constants of the page table walker.
// No dependencies; used by the walk engine and the top level.
package ptw_pkg;

  localparam int ADDR_W     = 48;
  localparam int PAGE_SHIFT = 12;
  localparam int INDEX_BITS = 9;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_WALK  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_TABLE = 2'd2,
    ST_OUTSIDE   = 2'd3
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [63:0]       vaddr;
    logic [ADDR_W-1:0] root_address;
    logic [11:0]       store_index;
    logic [63:0]       store_data;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] entry_address;
    logic [63:0]       entry_value;
  } rsp_t;

  typedef struct packed {
    logic [5:0]        va_bits;
    logic [ADDR_W-1:0] window_base;
  } cfg_t;

  // Highest level number of a walk (levels - 1). The depth is (va_bits-4)/9
  // clamped to 2..4, which reduces to two thresholds on va_bits.
  function automatic logic [1:0] top_level(input logic [5:0] vb);
    logic [1:0] lvl;
    if (vb >= 6'd40) begin
      lvl = 2'd3;
    end else if (vb >= 6'd31) begin
      lvl = 2'd2;
    end else begin
      lvl = 2'd1;
    end
    return lvl;
  endfunction

endpackage

// ----- rtl/ptw_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ptw_walk.sv -----
// Walk engine: sequences stores and table walks over the table memory.
// Depends on ptw_pkg, ptw_ram and assert_macros.svh.
`include "assert_macros.svh"

module ptw_walk import ptw_pkg::*; #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t res
);

  localparam int IDX_W = $clog2(TABLE_WORDS);
  localparam logic [ADDR_W-1:0] WIN_BYTES = ADDR_W'(TABLE_WORDS) * ADDR_W'(8);

  typedef enum logic [2:0] {S_IDLE, S_TBL, S_ENT, S_DATA, S_DONE} state_t;

  state_t            state;
  logic [1:0]        lvl;
  logic [ADDR_W-1:0] va;
  logic [ADDR_W-1:0] table_addr;
  logic [ADDR_W-1:0] ea;

  logic [ADDR_W-1:0]     off_t;
  logic [ADDR_W-1:0]     off_e;
  logic [INDEX_BITS-1:0] idx;
  logic [ADDR_W-1:0]     va_masked;
  logic                  store_in_range;
  logic                  ram_we;
  logic                  ram_re;
  logic [63:0]           ram_rdata;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    // A va_bits of zero keeps the whole address.
    for (int i = 0; i < ADDR_W; i++) begin
      va_masked[i] = req.vaddr[i] & ((cfg.va_bits == 6'd0) || (6'(i) < cfg.va_bits));
    end
  end

  assign idx   = va[PAGE_SHIFT + INDEX_BITS * lvl +: INDEX_BITS];
  assign off_t = table_addr - cfg.window_base;
  assign off_e = ea - cfg.window_base;

  assign store_in_range = ({20'd0, req.store_index} < 32'(TABLE_WORDS));
  assign ram_we = req_valid && (state == S_IDLE) && (req.operation == OP_STORE)
                  && store_in_range;
  assign ram_re = (state == S_ENT) && (off_e < WIN_BYTES);

  ptw_ram #(
    .WIDTH(64),
    .DEPTH(TABLE_WORDS)
  ) u_table_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(IDX_W'(req.store_index)),
    .wdata(req.store_data),
    .re   (ram_re),
    .raddr(off_e[IDX_W+2:3]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.operation == OP_STORE) begin
              res   <= '{status: ST_OK, entry_address: '0, entry_value: '0};
              state <= S_DONE;
            end else begin
              va         <= va_masked;
              table_addr <= req.root_address;
              lvl        <= top_level(cfg.va_bits);
              state      <= S_TBL;
            end
          end
        end
        S_TBL: begin
          if (off_t >= WIN_BYTES) begin
            res   <= '{status: ST_OUTSIDE, entry_address: '0, entry_value: '0};
            state <= S_DONE;
          end else begin
            ea    <= table_addr + ADDR_W'({idx, 3'b000});
            state <= S_ENT;
          end
        end
        S_ENT: begin
          if (off_e >= WIN_BYTES) begin
            res   <= '{status: ST_OUTSIDE, entry_address: '0, entry_value: '0};
            state <= S_DONE;
          end else begin
            state <= S_DATA;
          end
        end
        S_DATA: begin
          // The last-level entry is returned without checking its bits.
          if (lvl == 2'd0) begin
            res   <= '{status: ST_OK, entry_address: ea, entry_value: ram_rdata};
            state <= S_DONE;
          end else if (!ram_rdata[0]) begin
            res   <= '{status: ST_INVALID, entry_address: '0, entry_value: '0};
            state <= S_DONE;
          end else if (!ram_rdata[1]) begin
            res   <= '{status: ST_NOT_TABLE, entry_address: '0, entry_value: '0};
            state <= S_DONE;
          end else begin
            table_addr <= {ram_rdata[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            lvl        <= lvl - 2'd1;
            state      <= S_TBL;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PTW_NEVER(a_write_only_idle, clk, rst, ram_we && (state != S_IDLE),
             "table write outside the idle state")
  `PTW_NEVER(a_no_rw_overlap, clk, rst, ram_we && ram_re,
             "table read and write in the same cycle")
  `PTW_ASSERT(a_data_after_read, clk, rst,
              (state == S_DATA) |-> $past(ram_re),
              "descriptor used without a preceding memory read")
  `PTW_ASSERT(a_level_descends, clk, rst,
              ((state == S_TBL) && ($past(state) == S_DATA)) |-> (lvl == $past(lvl) - 2'd1),
              "walk level did not step down by one")

endmodule

// ----- rtl/page_table_walker.sv -----
// Page table walker top level: configuration registers, walk engine and
// result register. Depends on ptw_pkg and ptw_walk.
//
// A store request writes one 64-bit descriptor into the private table memory.
// Its response is registered in the walk engine, then in the output register.
// A walk request descends the translation tables through the table memory
// read port. Each level steps through the table window check and entry
// address, then the entry window check and memory read, then the descriptor
// check. A walk has 2 to 4 levels, from va_bits, and ends early when a check
// fails. The walk engine returns to idle on the edge at which its response
// enters the output register, so the next request can be accepted even if
// that response is not yet taken; until then no new request is accepted.
// The table memory has no reset; walks must only read words written before.
// Registers sit at byte addresses 0 (va_bits) and 8 (window_base).
module page_table_walker import ptw_pkg::*; #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Register select is paddr[3]; the low bits are the byte offset.
  localparam logic REG_VA_BITS     = 1'b0;
  localparam logic REG_WINDOW_BASE = 1'b1;

  cfg_t cfg;
  logic res_valid;
  logic res_ready;
  rsp_t res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.va_bits     <= 6'd48;
      cfg.window_base <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_VA_BITS:     cfg.va_bits     <= pwdata[5:0];
        REG_WINDOW_BASE: cfg.window_base <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_VA_BITS:     prdata = {58'd0, cfg.va_bits};
      REG_WINDOW_BASE: prdata = {{(64 - ADDR_W){1'b0}}, cfg.window_base};
      default:         prdata = '0;
    endcase
  end

  ptw_walk #(
    .TABLE_WORDS(TABLE_WORDS)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
      rsp       <= res;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
